FILE: rtl/lock_manager_with_waiters_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lock manager.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef LOCK_MANAGER_WITH_WAITERS_ASSERT_SVH
`define LOCK_MANAGER_WITH_WAITERS_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define LMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication: the consequent must hold in the cycle after the antecedent.
`define LMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lmw_pkg.sv
// ---------------------------------------------------------------------------
// Lock manager package
// Field widths, request and reply codes, and the reply word type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmw_pkg;

  // Fixed widths of the stream fields.
  localparam int ReqW    = 3;
  localparam int ClientW = 6;
  localparam int LockW   = 13;
  localparam int KindW   = 2;

  // Packed widths of the stream data buses, rounded up to whole bytes.
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_ALLOC   = 3'd0,
    REQ_ACQUIRE = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_JOIN    = 3'd3,
    REQ_LEAVE   = 3'd4
  } req_e;

  // Reply codes.
  typedef enum logic [KindW-1:0] {
    KIND_ALLOCATED = 2'd0,
    KIND_GRANTED   = 2'd1,
    KIND_RELEASED  = 2'd2,
    KIND_REFUSED   = 2'd3
  } kind_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  // One reply word.
  typedef struct packed {
    logic [ClientW-1:0] client;
    kind_e              kind;
    logic [LockW-1:0]   lock;
    logic               last;
  } reply_t;

endpackage

FILE: rtl/lock_manager_with_waiters.sv
// ---------------------------------------------------------------------------
// Lock manager with waiters
// Allocates, grants and releases locks for a set of client slots. A release
// hands the lock to the lowest-numbered present waiter, found by a scan.
// ---------------------------------------------------------------------------
// Channel   Direction  Bus     Fields (lowest bit first)
// s_axis    in         tdata   client_id[5:0], lock_id[18:6]
//                      tuser   req_type[2:0]
// m_axis    out        tdata   reply_client[5:0], reply_lock[18:6]
//                      tuser   reply_kind[1:0]
//                      tlast   last_reply
//
// A request is accepted in ST_IDLE and checked in ST_CHECK; any reply words
// are then presented in ST_OUT until the sink takes the last one. A release
// that finds the lock held scans the waiter table one slot a cycle, limited
// by the single read port of the waiter memory and its one comparator.
// The block takes one request at a time;
// s_axis_tready is high only while it is idle.
// The lock table needs no clearing pass: an entry is cleared when its id is
// allocated, and ids at or above the next free id are always refused.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lock_manager_with_waiters #(
  parameter int LOCK_COUNT   = 8192,
  parameter int CLIENT_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // client_id[5:0], lock_id[18:6], zero fill above.
  input  logic [lmw_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type[2:0].
  input  logic [lmw_pkg::ReqW-1:0]     s_axis_tuser,
  // Reply channel.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // reply_client[5:0], reply_lock[18:6], zero fill above.
  output logic [lmw_pkg::OutDataW-1:0] m_axis_tdata,
  // reply_kind[1:0].
  output logic [lmw_pkg::KindW-1:0]    m_axis_tuser,
  // last_reply.
  output logic                         m_axis_tlast
);

  import lmw_pkg::*;

  `include "lock_manager_with_waiters_assert.svh"

  localparam int LockAw  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int NextW   = $clog2(LOCK_COUNT + 1);
  localparam int CmpW    = (NextW > LockW) ? NextW : LockW;
  localparam int ClientAw = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
  localparam int CntW    = $clog2(CLIENT_COUNT + 1);

  // Control state.
  state_e               state_q, state_d;
  logic [NextW-1:0]     next_free_q, next_free_d;
  logic [CLIENT_COUNT-1:0] present_q, present_d;
  logic [CLIENT_COUNT-1:0] wvld_q, wvld_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic                 have2_q, have2_d;

  // Request and scan payload.
  logic [ReqW-1:0]      req_q, req_d;
  logic [ClientW-1:0]   client_q, client_d;
  logic [LockW-1:0]     lock_q, lock_d;
  logic                 chk_q, chk_d;
  logic [ClientAw-1:0]  cidx_q, cidx_d;
  reply_t               out_q, out_d;
  reply_t               out2_q, out2_d;

  // Lock table memory.
  logic                 held_mem [LOCK_COUNT];
  logic                 held_rd_q;
  logic                 held_re, held_we, held_wd;
  logic [LockAw-1:0]    held_ra, held_wa;

  // Waiter table memory.
  logic [LockW-1:0]     wait_mem [CLIENT_COUNT];
  logic [LockW-1:0]     wait_rd_q;
  logic                 wait_re, wait_we;
  logic [ClientAw-1:0]  wait_ra, wait_wa;

  // Decode helpers.
  logic                 in_acc;
  logic [ClientAw-1:0]  cidx;
  logic [ClientAw-1:0]  sidx;
  logic                 slot_ok, me_present, lock_ok, room;
  logic                 scan_hit, scan_done;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign cidx       = ClientAw'(client_q);
  assign sidx       = cnt_q[ClientAw-1:0];
  assign slot_ok    = 32'(client_q) < 32'(CLIENT_COUNT);
  assign me_present = slot_ok && present_q[cidx];
  assign lock_ok    = (lock_q != '0) && (CmpW'(lock_q) < CmpW'(next_free_q));
  assign room       = next_free_q != NextW'(LOCK_COUNT);

  // The shared comparator: one waiter entry against the released lock.
  assign scan_hit  = pend_q && chk_q && (wait_rd_q == lock_q);
  assign scan_done = pend_q && !scan_hit && (cnt_q == CntW'(CLIENT_COUNT));

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    next_free_d = next_free_q;
    present_d   = present_q;
    wvld_d      = wvld_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    have2_d     = have2_q;
    req_d       = req_q;
    client_d    = client_q;
    lock_d      = lock_q;
    chk_d       = chk_q;
    cidx_d      = cidx_q;
    out_d       = out_q;
    out2_d      = out2_q;
    held_re     = 1'b0;
    held_ra     = LockAw'(s_axis_tdata[ClientW +: LockW]);
    held_we     = 1'b0;
    held_wa     = LockAw'(lock_q);
    held_wd     = 1'b0;
    wait_re     = 1'b0;
    wait_ra     = sidx;
    wait_we     = 1'b0;
    wait_wa     = cidx;

    unique case (state_q)
      ST_IDLE: begin
        // Take a request and start the lock table read at its lock id.
        if (in_acc) begin
          req_d    = s_axis_tuser;
          client_d = s_axis_tdata[ClientW-1:0];
          lock_d   = s_axis_tdata[ClientW +: LockW];
          held_re  = 1'b1;
          state_d  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Default reply is a refusal to the requester.
        out_d   = '{client: client_q, kind: KIND_REFUSED, lock: '0, last: 1'b1};
        have2_d = 1'b0;
        state_d = ST_OUT;
        unique case (req_q) inside
          REQ_JOIN, REQ_LEAVE: begin
            if (slot_ok) begin
              present_d[cidx] = (req_q == REQ_JOIN);
              wvld_d[cidx]    = 1'b0;
            end
            state_d = ST_IDLE;
          end
          REQ_ALLOC: begin
            if (me_present && room) begin
              out_d.kind  = KIND_ALLOCATED;
              out_d.lock  = LockW'(next_free_q);
              held_we     = 1'b1;
              held_wa     = LockAw'(next_free_q);
              held_wd     = 1'b0;
              next_free_d = next_free_q + 1'b1;
            end
          end
          REQ_ACQUIRE: begin
            if (me_present && lock_ok) begin
              if (held_rd_q) begin
                // Park the client as a waiter, no reply.
                wait_we      = 1'b1;
                wvld_d[cidx] = 1'b1;
                state_d      = ST_IDLE;
              end else begin
                held_we    = 1'b1;
                held_wd    = 1'b1;
                out_d.kind = KIND_GRANTED;
                out_d.lock = lock_q;
              end
            end
          end
          REQ_RELEASE: begin
            if (me_present && lock_ok && held_rd_q) begin
              cnt_d   = '0;
              pend_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_SCAN: begin
        // Issue one waiter read a cycle; compare the entry read last cycle.
        if (cnt_q != CntW'(CLIENT_COUNT)) begin
          wait_re = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          pend_d  = 1'b1;
          chk_d   = present_q[sidx] && wvld_q[sidx];
          cidx_d  = sidx;
        end else begin
          pend_d = 1'b0;
        end
        if (scan_hit) begin
          // Hand the lock to this waiter; the lock stays held.
          wvld_d[cidx_q] = 1'b0;
          out_d   = '{client: ClientW'(cidx_q), kind: KIND_GRANTED, lock: lock_q,
                      last: 1'b0};
          out2_d  = '{client: client_q, kind: KIND_RELEASED, lock: lock_q, last: 1'b1};
          have2_d = 1'b1;
          state_d = ST_OUT;
        end else if (scan_done) begin
          // Nobody waits: mark the lock free.
          held_we = 1'b1;
          held_wd = 1'b0;
          out_d   = '{client: client_q, kind: KIND_RELEASED, lock: lock_q, last: 1'b1};
          have2_d = 1'b0;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        // Present reply words until the last one is taken.
        if (m_axis_tready) begin
          if (have2_q) begin
            out_d   = out2_q;
            have2_d = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= NextW'(1);
      present_q   <= '0;
      wvld_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      have2_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      present_q   <= present_d;
      wvld_q      <= wvld_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      have2_q     <= have2_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    client_q <= client_d;
    lock_q   <= lock_d;
    chk_q    <= chk_d;
    cidx_q   <= cidx_d;
    out_q    <= out_d;
    out2_q   <= out2_d;
  end

  // Lock table: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_mem[held_wa] <= held_wd;
    end
    if (held_re) begin
      held_rd_q <= held_mem[held_ra];
    end
  end

  // Waiter table: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_wa] <= lock_q;
    end
    if (wait_re) begin
      wait_rd_q <= wait_mem[wait_ra];
    end
  end

  // Stream ports.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {{(OutDataW - ClientW - LockW){1'b0}}, out_q.lock, out_q.client};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // Checks.
  `LMW_ASSERT(a_first_of_two, !m_axis_tvalid || m_axis_tlast || have2_q, "lone grant word")
  `LMW_ASSERT(a_next_id, (next_free_q != '0) && (next_free_q <= NextW'(LOCK_COUNT)), "bad next id")
  `LMW_ASSERT(a_scan_bound, (state_q != ST_SCAN) || (cnt_q <= CntW'(CLIENT_COUNT)), "scan overrun")
  `LMW_ASSERT_NEXT(a_grant_clears, (state_q == ST_SCAN) && scan_hit, !wvld_q[$past(cidx_q)], "waiter kept")

endmodule
